@@ rtl/dtbc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbc_pkg
// Shared types, codes and helpers for the debounced toggle button colour block.
// ----------------------------------------------------------------------------
package dtbc_pkg;

	localparam int STATES_MAX_DEF = 8;
	localparam int MAX_BRIGHT_DEF = 4095;

	localparam int IDX_W    = 4;
	localparam int CNT_W    = 5;
	localparam int MS_W     = 16;
	localparam int TIME_W   = 32;
	localparam int BRIGHT_W = 12;
	localparam int REQ_W    = 16;
	localparam int COLOR_W  = 3 * BRIGHT_W;
	localparam int KIND_W   = 3;
	localparam int REG_W    = 2;

	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 48;

	// reset values of the configuration registers
	localparam logic [CNT_W-1:0] TOGGLE_COUNT_RST = 5'd2;
	localparam logic [MS_W-1:0]  SWITCH_MS_RST    = 16'd50;
	localparam logic [MS_W-1:0]  STABLE_MS_RST    = 16'd50;

	typedef enum logic [KIND_W-1:0] {
		KIND_SAMPLE = 3'd0,
		KIND_WRITE  = 3'd1,
		KIND_READ   = 3'd2,
		KIND_DIRECT = 3'd3,
		KIND_OFF    = 3'd4
	} kind_t;

	typedef enum logic [REG_W-1:0] {
		REG_TOGGLE_COUNT = 2'd0,
		REG_SWITCH_MS    = 2'd1,
		REG_STABLE_MS    = 2'd2,
		REG_LEDS_ENABLED = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CNT_W-1:0] toggle_count;
		logic [MS_W-1:0]  switch_ms;
		logic [MS_W-1:0]  stable_ms;
		logic             leds_enabled;
	} cfg_t;

	// request from the datapath to the debounce unit
	typedef struct packed {
		logic              sample;
		logic              clear;
		logic              level;
		logic [TIME_W-1:0] now;
	} dbn_req_t;

	// debounce unit status back to the datapath
	typedef struct packed {
		logic             pend_q;
		logic             pend_nx;
		logic [IDX_W-1:0] idx_nx;
	} dbn_stat_t;

	// negative -> 0, above the ceiling -> ceiling
	function automatic logic [BRIGHT_W-1:0] clamp_bright(
		input logic signed [REQ_W-1:0] v,
		input logic [BRIGHT_W-1:0]     ceil_v
	);
		logic [BRIGHT_W-1:0] res;
		if (v < 0) begin
			res = '0;
		end else if (v > $signed({{(REQ_W-BRIGHT_W){1'b0}}, ceil_v})) begin
			res = ceil_v;
		end else begin
			res = v[BRIGHT_W-1:0];
		end
		return res;
	endfunction

endpackage

@@ rtl/dtbc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbc_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module dtbc_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/dtbc_debounce.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtbc_debounce
// Button debounce timers, accepted level, toggle index and pending flag.
// ----------------------------------------------------------------------------
module dtbc_debounce (
	input  logic                clk,
	input  logic                arst_n,
	input  dtbc_pkg::cfg_t      cfg,
	input  dtbc_pkg::dbn_req_t  req,
	output dtbc_pkg::dbn_stat_t stat
);

	logic                             level_q, level_nx;
	logic [dtbc_pkg::TIME_W-1:0]      sw_time_q, sw_time_nx;
	logic [dtbc_pkg::TIME_W-1:0]      match_time_q, match_time_nx;
	logic [dtbc_pkg::IDX_W-1:0]       idx_q, idx_nx, idx_inc;
	logic                             pend_q, pend_nx;
	logic [dtbc_pkg::TIME_W-1:0]      since_sw, since_match;
	logic                             take;

	// wrap-around elapsed times
	assign since_sw    = req.now - sw_time_q;
	assign since_match = req.now - match_time_q;
	assign take = (since_sw > {{(dtbc_pkg::TIME_W-dtbc_pkg::MS_W){1'b0}}, cfg.switch_ms})
		|| (since_match > {{(dtbc_pkg::TIME_W-dtbc_pkg::MS_W){1'b0}}, cfg.stable_ms});
	assign idx_inc = idx_q + 1'b1;

	always_comb begin
		level_nx      = level_q;
		sw_time_nx    = sw_time_q;
		match_time_nx = match_time_q;
		idx_nx        = idx_q;
		pend_nx       = pend_q;
		if (req.sample) begin
			if (req.level == level_q) begin
				match_time_nx = req.now;
			end else if (take) begin
				sw_time_nx = req.now;
				level_nx   = req.level;
				if (req.level) begin
					pend_nx = 1'b1;
					idx_nx  = ({1'b0, idx_inc} >= cfg.toggle_count) ? '0 : idx_inc;
				end
			end
		end
		if (req.clear) begin
			pend_nx = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q      <= 1'b0;
			sw_time_q    <= '0;
			match_time_q <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
		end else begin
			level_q      <= level_nx;
			sw_time_q    <= sw_time_nx;
			match_time_q <= match_time_nx;
			idx_q        <= idx_nx;
			pend_q       <= pend_nx;
		end
	end

	assign stat.pend_q  = pend_q;
	assign stat.pend_nx = pend_nx;
	assign stat.idx_nx  = idx_nx;

endmodule

@@ rtl/debounced_toggle_button_color.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// debounced_toggle_button_color
// Debounced multi-state toggle button selecting one RGB colour from a table.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake                Content
// s_axis    in   tvalid/tready            request: kind in tuser, sample/colour in tdata
// m_axis    out  tvalid/tready            one result per request
// cfg       in   cfg_valid/cfg_ready      register index and write data
//
// One request per cycle sustained while m_axis takes results; a request taken
// passes the request stage (with the colour table read) and then the output
// register, from which m_axis offers its result. The registered table read sets
// the request stage. Reset clears all control state and the table valid bits at
// once; no clearing pass. A stalled output holds one result in the output register
// and one in the request stage, then s_axis_tready drops until one moves.
//
module debounced_toggle_button_color #(
	parameter int STATES_MAX = dtbc_pkg::STATES_MAX_DEF,
	parameter int MAX_BRIGHT = dtbc_pkg::MAX_BRIGHT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// from the lowest bit: pin_level[0], now_ms[32:1], entry[40:33],
	// red_in[56:41], green_in[72:57], blue_in[88:73], zero pad
	input  logic [dtbc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// kind[2:0]
	input  logic [dtbc_pkg::KIND_W-1:0]         s_axis_tuser,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// from the lowest bit: changed[0], toggle_state[4:1], accepted[5],
	// led_update[6], red_out[18:7], green_out[30:19], blue_out[42:31], zero pad
	output logic [dtbc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dtbc_pkg::REG_W-1:0]          cfg_index,
	input  logic [dtbc_pkg::MS_W-1:0]           cfg_data
);

	localparam int AW = $clog2(STATES_MAX);
	localparam logic [dtbc_pkg::BRIGHT_W-1:0] BRIGHT_CEIL = dtbc_pkg::BRIGHT_W'(MAX_BRIGHT);
	localparam logic [7:0] ENTRY_TOP = 8'(STATES_MAX - 1);
	localparam logic [dtbc_pkg::IDX_W-1:0] IDX_TOP = dtbc_pkg::IDX_W'(STATES_MAX - 1);
	localparam logic [dtbc_pkg::CNT_W-1:0] CNT_TOP = dtbc_pkg::CNT_W'(STATES_MAX);

	// ---- configuration registers; always ready; the user must write them only while idle, not enforced here
	dtbc_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.toggle_count <= dtbc_pkg::TOGGLE_COUNT_RST;
			cfg_q.switch_ms    <= dtbc_pkg::SWITCH_MS_RST;
			cfg_q.stable_ms    <= dtbc_pkg::STABLE_MS_RST;
			cfg_q.leds_enabled <= 1'b0;
		end else if (cfg_valid) begin
			case (dtbc_pkg::reg_idx_t'(cfg_index))
				dtbc_pkg::REG_TOGGLE_COUNT: begin
					// illegal counts fall back to two states
					if (cfg_data[dtbc_pkg::CNT_W-1:0] >= dtbc_pkg::TOGGLE_COUNT_RST
						&& cfg_data[dtbc_pkg::CNT_W-1:0] <= CNT_TOP) begin
						cfg_q.toggle_count <= cfg_data[dtbc_pkg::CNT_W-1:0];
					end else begin
						cfg_q.toggle_count <= dtbc_pkg::TOGGLE_COUNT_RST;
					end
				end
				dtbc_pkg::REG_SWITCH_MS:    cfg_q.switch_ms    <= cfg_data;
				dtbc_pkg::REG_STABLE_MS:    cfg_q.stable_ms    <= cfg_data;
				dtbc_pkg::REG_LEDS_ENABLED: cfg_q.leds_enabled <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ---- request unpacking
	logic                                 in_acc;
	logic                                 adv;
	logic                                 pin_level;
	logic [dtbc_pkg::TIME_W-1:0]          now_ms;
	logic [7:0]                           entry;
	logic signed [dtbc_pkg::REQ_W-1:0]    red_in, green_in, blue_in;
	logic [dtbc_pkg::BRIGHT_W-1:0]        red_c, green_c, blue_c;
	dtbc_pkg::kind_t                      kind;

	assign pin_level = s_axis_tdata[0];
	assign now_ms    = s_axis_tdata[32:1];
	assign entry     = s_axis_tdata[40:33];
	assign red_in    = $signed(s_axis_tdata[56:41]);
	assign green_in  = $signed(s_axis_tdata[72:57]);
	assign blue_in   = $signed(s_axis_tdata[88:73]);
	assign kind      = dtbc_pkg::kind_t'(s_axis_tuser);

	assign red_c   = dtbc_pkg::clamp_bright(red_in, BRIGHT_CEIL);
	assign green_c = dtbc_pkg::clamp_bright(green_in, BRIGHT_CEIL);
	assign blue_c  = dtbc_pkg::clamp_bright(blue_in, BRIGHT_CEIL);

	// ---- pipeline control: request stage (s1) then output register
	logic s1_v_q;
	logic out_v_q;

	assign adv           = !out_v_q || m_axis_tready;
	assign s_axis_tready = !s1_v_q || adv;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// ---- debounce and toggle state
	dtbc_pkg::dbn_req_t  dbn_req;
	dtbc_pkg::dbn_stat_t dbn_stat;

	assign dbn_req.sample = in_acc && (kind == dtbc_pkg::KIND_SAMPLE);
	assign dbn_req.clear  = in_acc && (kind == dtbc_pkg::KIND_READ);
	assign dbn_req.level  = pin_level;
	assign dbn_req.now    = now_ms;

	dtbc_debounce u_debounce (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.req    (dbn_req),
		.stat   (dbn_stat)
	);

	// ---- colour table: RAM plus per-entry valid bits (unwritten reads as 0)
	logic [7:0]                      entry_sat;
	logic [AW-1:0]                   waddr;
	logic [dtbc_pkg::IDX_W-1:0]      idx_sat;
	logic [AW-1:0]                   raddr;
	logic                            tbl_we, tbl_re;
	logic [dtbc_pkg::COLOR_W-1:0]    tbl_rdata;
	logic [STATES_MAX-1:0]           tbl_vld_q;

	assign entry_sat = (entry > ENTRY_TOP) ? ENTRY_TOP : entry;
	assign waddr     = entry_sat[AW-1:0];
	// the index after this request equals the current one for a read
	assign idx_sat   = (dbn_stat.idx_nx > IDX_TOP) ? IDX_TOP : dbn_stat.idx_nx;
	assign raddr     = idx_sat[AW-1:0];
	assign tbl_we    = in_acc && (kind == dtbc_pkg::KIND_WRITE);
	assign tbl_re    = in_acc && (kind == dtbc_pkg::KIND_READ);

	dtbc_ram #(
		.WIDTH (dtbc_pkg::COLOR_W),
		.DEPTH (STATES_MAX)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (waddr),
		.wdata ({blue_c, green_c, red_c}),
		.re    (tbl_re),
		.raddr (raddr),
		.rdata (tbl_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tbl_vld_q <= '0;
		end else if (tbl_we) begin
			tbl_vld_q[waddr] <= 1'b1;
		end
	end

	// ---- request stage: everything but the table colour is settled here
	logic                           changed_s1, accepted_s1, upd_s1;
	logic                           use_tbl_s1, tbl_hit_s1;
	logic [dtbc_pkg::IDX_W-1:0]     toggle_s1;
	logic [dtbc_pkg::BRIGHT_W-1:0]  red_s1, green_s1, blue_s1;
	logic                           changed_d, accepted_d, upd_d, use_tbl_d;
	logic [dtbc_pkg::BRIGHT_W-1:0]  red_d, green_d, blue_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_acc) begin
			s1_v_q <= 1'b1;
		end else if (adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_comb begin
		changed_d  = 1'b0;
		accepted_d = 1'b0;
		upd_d      = 1'b0;
		use_tbl_d  = 1'b0;
		red_d      = '0;
		green_d    = '0;
		blue_d     = '0;
		case (kind)
			dtbc_pkg::KIND_SAMPLE: changed_d = dbn_stat.pend_nx;
			dtbc_pkg::KIND_WRITE: begin
				accepted_d = ({3'b000, cfg_q.toggle_count} > entry_sat)
					&& cfg_q.leds_enabled;
			end
			dtbc_pkg::KIND_READ: begin
				// colour only once per pending change, and only with LEDs on
				upd_d     = cfg_q.leds_enabled && dbn_stat.pend_q;
				use_tbl_d = cfg_q.leds_enabled && dbn_stat.pend_q;
			end
			dtbc_pkg::KIND_DIRECT: begin
				upd_d   = 1'b1;
				red_d   = red_c;
				green_d = green_c;
				blue_d  = blue_c;
			end
			dtbc_pkg::KIND_OFF: upd_d = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			toggle_s1   <= dbn_stat.idx_nx;
			changed_s1  <= changed_d;
			accepted_s1 <= accepted_d;
			upd_s1      <= upd_d;
			use_tbl_s1  <= use_tbl_d;
			tbl_hit_s1  <= tbl_vld_q[raddr];
			red_s1      <= red_d;
			green_s1    <= green_d;
			blue_s1     <= blue_d;
		end
	end

	// ---- output register
	logic [dtbc_pkg::COLOR_W-1:0] color_s1;
	logic [dtbc_pkg::OUT_TDATA_W-1:0] out_q;

	always_comb begin
		if (use_tbl_s1) begin
			color_s1 = tbl_hit_s1 ? tbl_rdata : '0;
		end else begin
			color_s1 = {blue_s1, green_s1, red_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_v_q) begin
			out_q <= {5'b00000, color_s1, upd_s1, accepted_s1, toggle_s1, changed_s1};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q;

	// ---- checks
	a_toggle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[4:1] <= IDX_TOP))
		else $error("toggle state beyond table size");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && kind == dtbc_pkg::KIND_READ) |=> !dbn_stat.pend_q)
		else $error("pending change not cleared by read");

	a_accept_no_drive: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(m_axis_tdata[5] && m_axis_tdata[6]))
		else $error("write acceptance together with LED update");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v_q && out_v_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("request taken with both stages full and stalled");

endmodule

@@ bench/tb_debounced_toggle_button_color.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_debounced_toggle_button_color
// Self-checking bench for the debounced toggle button colour block.
//
// Requests go in on s_axis with the kind in tuser. A behavioural copy of the
// debounce, toggle and colour table logic predicts one result per request.
// Results leaving m_axis are checked field by field, in order. The run covers
// a directed set of corner requests, random button traffic with bounce under
// several register settings, a long output hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb_debounced_toggle_button_color;

	localparam int STATES_MAX  = dtbc_pkg::STATES_MAX_DEF;
	localparam int MAX_BRIGHT  = dtbc_pkg::MAX_BRIGHT_DEF;
	localparam int AW          = $clog2(STATES_MAX);
	localparam int CYCLE_LIMIT = 400000;

	// kinds beyond the defined set; the block must leave its state alone
	localparam logic [dtbc_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
	localparam logic [dtbc_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

	// one request as the block sees it
	typedef struct packed {
		logic [dtbc_pkg::KIND_W-1:0]  kind;
		logic                         level;
		logic [dtbc_pkg::TIME_W-1:0]  now;
		logic [7:0]                   entry;
		logic signed [15:0]           red;
		logic signed [15:0]           green;
		logic signed [15:0]           blue;
	} request_t;

	// result word, laid out as m_axis_tdata from the top bit down
	typedef struct packed {
		logic [4:0]                    pad;
		logic [dtbc_pkg::BRIGHT_W-1:0] blue;
		logic [dtbc_pkg::BRIGHT_W-1:0] green;
		logic [dtbc_pkg::BRIGHT_W-1:0] red;
		logic                          led_update;
		logic                          accepted;
		logic [dtbc_pkg::IDX_W-1:0]    toggle_state;
		logic                          changed;
	} result_t;

	typedef struct packed {
		logic [dtbc_pkg::BRIGHT_W-1:0] r;
		logic [dtbc_pkg::BRIGHT_W-1:0] g;
		logic [dtbc_pkg::BRIGHT_W-1:0] b;
	} rgb_t;

	// ------------------------------------------------------------------------
	// DUT connections, inputs all known from time zero
	// ------------------------------------------------------------------------
	logic                             clk           = 1'b0;
	logic                             arst_n        = 1'b0;
	logic [dtbc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic [dtbc_pkg::KIND_W-1:0]      s_axis_tuser  = '0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [dtbc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic                             cfg_valid     = 1'b0;
	logic                             cfg_ready;
	logic [dtbc_pkg::REG_W-1:0]       cfg_index     = '0;
	logic [dtbc_pkg::MS_W-1:0]        cfg_data      = '0;

	debounced_toggle_button_color u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor state: register mirror plus the button and table state
	// ------------------------------------------------------------------------
	logic [dtbc_pkg::CNT_W-1:0]  cfg_count   = dtbc_pkg::TOGGLE_COUNT_RST;
	logic [dtbc_pkg::MS_W-1:0]   cfg_sw_ms   = dtbc_pkg::SWITCH_MS_RST;
	logic [dtbc_pkg::MS_W-1:0]   cfg_st_ms   = dtbc_pkg::STABLE_MS_RST;
	logic                        cfg_leds_on = 1'b0;

	logic                        btn_level    = 1'b0;
	logic [dtbc_pkg::TIME_W-1:0] btn_switch_t = '0;
	logic [dtbc_pkg::TIME_W-1:0] btn_match_t  = '0;
	logic [dtbc_pkg::IDX_W-1:0]  toggle_idx   = '0;
	logic                        change_pend  = 1'b0;
	rgb_t                        colour_mem [STATES_MAX] = '{default: '0};

	result_t             led_results_due [$];

	// bookkeeping
	int unsigned mismatch_count  = 0;
	int unsigned requests_sent   = 0;
	int unsigned results_checked = 0;
	int unsigned presses_taken   = 0;
	int unsigned config_loads    = 0;
	int unsigned in_stall_cycles = 0;
	int unsigned cycle_count     = 0;

	// stimulus shaping
	bit          tx_idle_on  = 1'b1;
	bit          rx_idle_on  = 1'b1;
	int unsigned hold_len    = 0;
	int unsigned hold_asks   = 0;
	int unsigned hold_seen   = 0;
	int unsigned rx_stall_left = 0;
	int unsigned rx_pick;
	logic [dtbc_pkg::TIME_W-1:0] clock_ms   = '0;
	logic                        phys_level = 1'b0;

	result_t seen_result;
	result_t due_result;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------
	// negative -> 0, above the ceiling -> ceiling
	function automatic logic [dtbc_pkg::BRIGHT_W-1:0] limit_brightness(
			input logic signed [15:0] v);
		logic [dtbc_pkg::BRIGHT_W-1:0] res;
		if (v[15]) begin
			res = '0;
		end else if (v > MAX_BRIGHT) begin
			res = MAX_BRIGHT[dtbc_pkg::BRIGHT_W-1:0];
		end else begin
			res = v[dtbc_pkg::BRIGHT_W-1:0];
		end
		return res;
	endfunction

	// advances the mirrored state by one request and returns its result
	function automatic result_t predict_button_result(input request_t rq);
		result_t                     res;
		logic [dtbc_pkg::TIME_W-1:0] since_switch;
		logic [dtbc_pkg::TIME_W-1:0] since_match;
		logic [7:0]                  ent;
		logic [dtbc_pkg::IDX_W-1:0]  sel;
		res = '0;
		case (rq.kind)
			dtbc_pkg::KIND_SAMPLE: begin
				since_switch = rq.now - btn_switch_t;
				since_match  = rq.now - btn_match_t;
				if (rq.level == btn_level) begin
					btn_match_t = rq.now;
				end else if (since_switch > {16'h0, cfg_sw_ms} ||
				             since_match > {16'h0, cfg_st_ms}) begin
					btn_switch_t = rq.now;
					btn_level    = rq.level;
					// only a press advances; a release is just timed
					if (rq.level) begin
						change_pend = 1'b1;
						toggle_idx  = toggle_idx + 1'b1;
						if ({1'b0, toggle_idx} >= cfg_count)
							toggle_idx = '0;
						presses_taken++;
					end
				end
				res.changed = change_pend;
			end
			dtbc_pkg::KIND_WRITE: begin
				ent = (rq.entry > STATES_MAX - 1) ? 8'(STATES_MAX - 1) : rq.entry;
				colour_mem[ent[AW-1:0]].r = limit_brightness(rq.red);
				colour_mem[ent[AW-1:0]].g = limit_brightness(rq.green);
				colour_mem[ent[AW-1:0]].b = limit_brightness(rq.blue);
				res.accepted = (ent < cfg_count) && cfg_leds_on;
			end
			dtbc_pkg::KIND_READ: begin
				if (cfg_leds_on && change_pend) begin
					sel = (toggle_idx > STATES_MAX - 1) ?
						dtbc_pkg::IDX_W'(STATES_MAX - 1) : toggle_idx;
					res.led_update = 1'b1;
					res.red   = colour_mem[sel[AW-1:0]].r;
					res.green = colour_mem[sel[AW-1:0]].g;
					res.blue  = colour_mem[sel[AW-1:0]].b;
				end
				// flag goes whether or not a colour went out
				change_pend = 1'b0;
			end
			dtbc_pkg::KIND_DIRECT: begin
				res.led_update = 1'b1;
				res.red   = limit_brightness(rq.red);
				res.green = limit_brightness(rq.green);
				res.blue  = limit_brightness(rq.blue);
			end
			dtbc_pkg::KIND_OFF: begin
				res.led_update = 1'b1;
			end
			default: begin
			end
		endcase
		res.toggle_state = toggle_idx;
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// Request builders
	// ------------------------------------------------------------------------
	// every field random; callers overwrite what matters for the kind
	function automatic request_t random_fields(input logic [dtbc_pkg::KIND_W-1:0] kind);
		request_t rq;
		rq.kind  = kind;
		rq.level = 1'($urandom_range(0, 1));
		rq.now   = $urandom();
		rq.entry = 8'($urandom_range(0, 255));
		rq.red   = 16'($urandom_range(0, 16'hFFFF));
		rq.green = 16'($urandom_range(0, 16'hFFFF));
		rq.blue  = 16'($urandom_range(0, 16'hFFFF));
		return rq;
	endfunction

	function automatic request_t sample_req(input logic level,
			input logic [dtbc_pkg::TIME_W-1:0] now);
		request_t rq;
		rq       = random_fields(dtbc_pkg::KIND_SAMPLE);
		rq.level = level;
		rq.now   = now;
		return rq;
	endfunction

	function automatic request_t colour_req(input logic [dtbc_pkg::KIND_W-1:0] kind,
			input logic [7:0] entry,
			input logic signed [15:0] r, input logic signed [15:0] g,
			input logic signed [15:0] b);
		request_t rq;
		rq       = random_fields(kind);
		rq.entry = entry;
		rq.red   = r;
		rq.green = g;
		rq.blue  = b;
		return rq;
	endfunction

	// brightness requests clustered around the clamp points
	function automatic logic signed [15:0] pick_brightness();
		int unsigned p;
		logic signed [15:0] v;
		p = $urandom_range(0, 9);
		if (p < 4)
			v = 16'($urandom_range(0, MAX_BRIGHT));
		else if (p < 6)
			v = 16'($urandom_range(MAX_BRIGHT - 4, MAX_BRIGHT + 4));
		else if (p < 7)
			v = 16'(16'hFFFF - $urandom_range(0, 3));
		else
			v = 16'($urandom_range(0, 16'hFFFF));
		return v;
	endfunction

	// ------------------------------------------------------------------------
	// Request channel driver
	// ------------------------------------------------------------------------
	// call just after a rising edge; returns just after the accepting edge, or after the idle gap that follows it
	task automatic send_request(input request_t rq);
		result_t     want;
		int unsigned gap;
		int unsigned p;
		s_axis_tuser  <= rq.kind;
		s_axis_tdata  <= {7'b0, rq.blue, rq.green, rq.red, rq.entry, rq.now, rq.level};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		want = predict_button_result(rq);
		led_results_due.push_back(want);
		requests_sent++;
		gap = 0;
		if (tx_idle_on) begin
			p = $urandom_range(0, 99);
			if (p >= 94)
				gap = $urandom_range(10, 40);
			else if (p >= 60)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// random traffic: mostly a bouncing button on a running clock, plus the
	// other kinds and some free noise samples
	task automatic send_random_item();
		request_t                    rq;
		int unsigned                 pick;
		int unsigned                 thr;
		logic [dtbc_pkg::TIME_W-1:0] delta;
		pick = $urandom_range(0, 99);
		if (pick < 58) begin
			thr  = 32'((cfg_sw_ms > cfg_st_ms) ? cfg_sw_ms : cfg_st_ms);
			pick = $urandom_range(0, 99);
			if (pick < 50)
				delta = $urandom_range(0, 40);
			else if (pick < 85)
				delta = $urandom_range(0, 2 * thr + 2);
			else if (pick < 95)
				delta = thr + $urandom_range(0, 1);   // right on the threshold
			else
				delta = $urandom();                   // long idle, may wrap
			clock_ms = clock_ms + delta;
			if ($urandom_range(0, 99) < 20)
				phys_level = ~phys_level;
			// contact bounce: the odd sample reads the other level
			rq = sample_req(($urandom_range(0, 99) < 15) ? ~phys_level : phys_level, clock_ms);
		end else if (pick < 73) begin
			rq = random_fields(dtbc_pkg::KIND_READ);
		end else if (pick < 83) begin
			rq = colour_req(dtbc_pkg::KIND_WRITE, 8'($urandom_range(0, 255)),
				pick_brightness(), pick_brightness(), pick_brightness());
			if ($urandom_range(0, 4) != 0)
				rq.entry = 8'($urandom_range(0, STATES_MAX + 1));
		end else if (pick < 90) begin
			rq = colour_req(dtbc_pkg::KIND_DIRECT, 8'($urandom_range(0, 255)),
				pick_brightness(), pick_brightness(), pick_brightness());
		end else if (pick < 95) begin
			rq = random_fields(dtbc_pkg::KIND_OFF);
		end else if (pick < 97) begin
			rq = random_fields(3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST)));
		end else begin
			rq = random_fields(dtbc_pkg::KIND_SAMPLE);
		end
		send_request(rq);
	endtask

	// ------------------------------------------------------------------------
	// Register channel
	// ------------------------------------------------------------------------
	// leaves cfg_valid high; load_config lowers it after the last write
	task automatic write_register(input dtbc_pkg::reg_idx_t idx,
			input logic [dtbc_pkg::MS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			dtbc_pkg::REG_TOGGLE_COUNT:
				cfg_count = (value[4:0] >= 2 && value[4:0] <= STATES_MAX) ?
					value[4:0] : dtbc_pkg::TOGGLE_COUNT_RST;
			dtbc_pkg::REG_SWITCH_MS:    cfg_sw_ms   = value;
			dtbc_pkg::REG_STABLE_MS:    cfg_st_ms   = value;
			dtbc_pkg::REG_LEDS_ENABLED: cfg_leds_on = value[0];
			default: begin
			end
		endcase
	endtask

	// only touched once the block is empty; unused upper bits carry junk
	task automatic load_config(input logic [4:0] count_raw,
			input logic [dtbc_pkg::MS_W-1:0] sw_ms,
			input logic [dtbc_pkg::MS_W-1:0] st_ms, input logic leds);
		logic [10:0] hi_count;
		logic [14:0] hi_leds;
		hi_count = 11'($urandom_range(0, 2047));
		hi_leds  = 15'($urandom_range(0, 32767));
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (led_results_due.size() != 0);
		repeat (4) @(posedge clk);
		write_register(dtbc_pkg::REG_TOGGLE_COUNT, {hi_count, count_raw});
		write_register(dtbc_pkg::REG_SWITCH_MS, sw_ms);
		write_register(dtbc_pkg::REG_STABLE_MS, st_ms);
		write_register(dtbc_pkg::REG_LEDS_ENABLED, {hi_leds, leds});
		cfg_valid <= 1'b0;
		config_loads++;
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// reset values, debounce edges, clamps, wrap of the ms clock, every kind
	task automatic test_directed();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_request(random_fields(dtbc_pkg::KIND_READ));  // nothing pending yet
		send_request(sample_req(1'b0, 32'd0));
		send_request(sample_req(1'b1, 32'd10));            // too soon
		send_request(sample_req(1'b1, 32'd50));            // exactly on the hold-off
		send_request(sample_req(1'b1, 32'd51));            // first press
		send_request(random_fields(dtbc_pkg::KIND_READ));  // LEDs off: flag just clears
		send_request(sample_req(1'b0, 32'd60));
		send_request(sample_req(1'b1, 32'hFFFF_FFF0));     // wraps the two-state toggle
		send_request(sample_req(1'b0, 32'h0000_0010));     // elapsed time across wrap
		send_request(sample_req(1'b0, 32'hFFFF_FFFF));
		send_request(colour_req(dtbc_pkg::KIND_WRITE, 8'd0, -16'sd1, 16'sd4096, 16'sd32767));
		send_request(colour_req(dtbc_pkg::KIND_WRITE, 8'd255, -16'sd32768, 16'sd0,
			16'sd4095));
		send_request(colour_req(dtbc_pkg::KIND_WRITE, 8'd1, 16'sd4095, 16'sd4094, 16'sd1));
		send_request(colour_req(dtbc_pkg::KIND_DIRECT, 8'd0, -16'sd32768, 16'sd32767,
			16'sd4095));
		send_request(colour_req(dtbc_pkg::KIND_DIRECT, 8'd7, 16'sd0, 16'sd4096, -16'sd1));
		send_request(random_fields(dtbc_pkg::KIND_OFF));
		for (int k = KIND_SPARE_FIRST; k <= KIND_SPARE_LAST; k++)
			send_request(random_fields(3'(k)));
		// LEDs on, no debounce at all
		load_config(5'd8, 16'd0, 16'd0, 1'b1);
		send_request(random_fields(dtbc_pkg::KIND_READ));  // pending press shows entry 0
		send_request(sample_req(1'b1, 32'd100));
		send_request(sample_req(1'b0, 32'd100));           // zero since the switch, but taken on the stable timer
		send_request(sample_req(1'b0, 32'd101));
		send_request(sample_req(1'b1, 32'd102));
		send_request(random_fields(dtbc_pkg::KIND_READ));
	endtask

	// random traffic over a spread of settings, extremes included
	task automatic test_random_phases();
		logic [4:0]                counts [8] = '{5'd2, 5'd8, 5'd16, 5'd3, 5'd0, 5'd31,
		                                          5'd5, 5'd7};
		logic [dtbc_pkg::MS_W-1:0] sws    [8] = '{16'd50, 16'd0, 16'd65535, 16'd10,
		                                          16'd5, 16'd100, 16'd20, 16'd65535};
		logic [dtbc_pkg::MS_W-1:0] sts    [8] = '{16'd50, 16'd0, 16'd65535, 16'd200,
		                                          16'd0, 16'd7, 16'd30, 16'd0};
		logic                      leds   [8] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0,
		                                          1'b1, 1'b1};
		for (int p = 0; p < 8; p++) begin
			if (p == 6)
				load_config(5'($urandom_range(0, 31)), 16'($urandom_range(0, 300)),
					16'($urandom_range(0, 300)), 1'($urandom_range(0, 1)));
			else
				load_config(counts[p], sws[p], sts[p], leds[p]);
			// some phases run without any idling on one side or the other
			tx_idle_on = (p % 3 != 0);
			rx_idle_on = (p % 4 != 1);
			repeat (55) send_random_item();
		end
	endtask

	// output held off for a long stretch while requests keep coming
	task automatic test_backpressure();
		load_config(5'd8, 16'd20, 16'd20, 1'b1);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		hold_len   = 300;
		hold_asks++;
		repeat (40) send_random_item();
	endtask

	// halfway through, the sender waits for every result before carrying on
	task automatic test_drain_pause();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (15) send_random_item();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (led_results_due.size() != 0);
		repeat (15) send_random_item();
	endtask

	// ------------------------------------------------------------------------
	// Result receiver: random stalls, plus long hold-offs on demand
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen     = hold_asks;
			rx_stall_left = hold_len;
		end
		if (rx_stall_left > 0) begin
			m_axis_tready <= 1'b0;
			rx_stall_left--;
		end else if (!rx_idle_on) begin
			m_axis_tready <= 1'b1;
		end else begin
			rx_pick = $urandom_range(0, 99);
			if (rx_pick < 70) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= 1'b0;
				rx_stall_left = (rx_pick < 97) ? $urandom_range(0, 2) : $urandom_range(20, 60);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result checker: oldest prediction against each accepted result
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			seen_result = m_axis_tdata;
			if (led_results_due.size() == 0) begin
				if (mismatch_count < 10)
					$display("result with no request outstanding: %h", m_axis_tdata);
				mismatch_count++;
			end else begin
				due_result = led_results_due.pop_front();
				results_checked++;
				if (seen_result.changed      !== due_result.changed      ||
				    seen_result.toggle_state !== due_result.toggle_state ||
				    seen_result.accepted     !== due_result.accepted     ||
				    seen_result.led_update   !== due_result.led_update   ||
				    seen_result.red          !== due_result.red          ||
				    seen_result.green        !== due_result.green        ||
				    seen_result.blue         !== due_result.blue         ||
				    seen_result.pad          !== due_result.pad) begin
					if (mismatch_count < 10) begin
						$display("mismatch on result %0d", results_checked);
						$display("  exp chg=%0d st=%0d acc=%0d upd=%0d rgb=%0d/%0d/%0d pad=%h",
							due_result.changed, due_result.toggle_state, due_result.accepted,
							due_result.led_update, due_result.red, due_result.green,
							due_result.blue, due_result.pad);
						$display("  got chg=%0d st=%0d acc=%0d upd=%0d rgb=%0d/%0d/%0d pad=%h",
							seen_result.changed, seen_result.toggle_state, seen_result.accepted,
							seen_result.led_update, seen_result.red, seen_result.green,
							seen_result.blue, seen_result.pad);
					end
					mismatch_count++;
				end
			end
		end
	end

	// watchdog and input stall count
	always @(posedge clk) begin
		cycle_count++;
		if (s_axis_tvalid && !s_axis_tready)
			in_stall_cycles++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, led_results_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phases();
		test_backpressure();
		test_drain_pause();

		// drain, then give the two-stage pipe time to show any stray result
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (led_results_due.size() != 0);
		repeat (10) @(posedge clk);
		if (led_results_due.size() != 0)
			mismatch_count++;

		$display("%0d requests over %0d register loads, %0d presses taken, %0d results checked",
			requests_sent, config_loads, presses_taken, results_checked);
		$display("request channel held back for %0d cycles", in_stall_cycles);
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches", mismatch_count);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
